// ===== sv/ffp_pkg.sv =====
`default_nettype none
package ffp_pkg;

	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] END_BYTE   = 8'hFE;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd1;

	localparam int RESET_FRAME_LENGTH  = 12288;
	localparam int RESET_PAYLOAD_LIMIT = 256;

	// descriptor for the byte engine: one input item and what goes around it
	typedef struct packed {
		logic [7:0]  pixel;
		logic        hdr;
		logic        frag_end;
		logic        frame_end;
		logic [15:0] frag_index;
		logic [15:0] frag_total;
		logic [15:0] pay_len;
	} desc_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

endpackage
`default_nettype wire

// ===== sv/ffp_front.sv =====
`default_nettype none
module ffp_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [7:0]                    pixel_value,
	input  wire logic                          cfg_we,
	input  wire logic [ffp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data,
	input  wire logic                          q_full,
	output logic                               q_push,
	output ffp_pkg::desc_t                     q_desc
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic [4:0] DIV_LAST = 5'd16;

	logic [1:0]  state_q;
	logic [15:0] frame_len_q, pay_lim_q;
	logic [7:0]  pix_q;
	logic [15:0] idx_q, pos_q, cur_len_q, left_q, total_q;
	logic [16:0] dvd_q;
	logic [15:0] rem_q;
	logic [4:0]  div_cnt_q;

	logic        accept;
	logic [15:0] lim, len;
	logic [16:0] r_trial, dvd_init;
	logic        ge;
	logic [15:0] rem_next;
	logic [15:0] seg_len, cur_len, pos_n, left_n;
	logic        hdr, frag_end, frame_end;

	assign full   = (state_q != ST_IDLE);
	assign accept = push && !full;

	assign lim      = (pay_lim_q == 16'd0) ? 16'd1 : pay_lim_q;
	assign len      = (frame_len_q == 16'd0) ? 16'd1 : frame_len_q;
	assign dvd_init = {1'b0, len} + {1'b0, lim} - 17'd1;

	// restoring divider, one quotient bit a cycle
	assign r_trial  = {rem_q, dvd_q[16]};
	assign ge       = (r_trial >= {1'b0, lim});
	always_comb begin
		rem_next = r_trial[15:0];
		if (ge) begin
			rem_next = 16'(r_trial - {1'b0, lim});
		end
	end

	assign hdr       = (pos_q == 16'd0);
	assign seg_len   = (left_q < lim) ? left_q : lim;
	assign cur_len   = hdr ? seg_len : cur_len_q;
	assign pos_n     = pos_q + 16'd1;
	assign left_n    = left_q - 16'd1;
	assign frame_end = (left_n == 16'd0);
	assign frag_end  = (pos_n >= cur_len) || frame_end;

	assign q_push = (state_q == ST_EMIT) && !q_full;

	always_comb begin
		q_desc            = '0;
		q_desc.pixel      = pix_q;
		q_desc.hdr        = hdr;
		q_desc.frag_end   = frag_end;
		q_desc.frame_end  = frame_end;
		q_desc.frag_index = idx_q;
		q_desc.frag_total = total_q;
		q_desc.pay_len    = cur_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= 16'(ffp_pkg::RESET_FRAME_LENGTH);
			pay_lim_q   <= 16'(ffp_pkg::RESET_PAYLOAD_LIMIT);
		end else if (cfg_we) begin
			case (cfg_index)
				ffp_pkg::REG_FRAME_LENGTH:  frame_len_q <= cfg_data;
				ffp_pkg::REG_PAYLOAD_LIMIT: pay_lim_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			pos_q     <= '0;
			cur_len_q <= '0;
			left_q    <= '0;
			total_q   <= '0;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (left_q == 16'd0) begin
							// item opens a frame
							left_q    <= len;
							idx_q     <= '0;
							pos_q     <= '0;
							div_cnt_q <= '0;
							state_q   <= ST_DIV;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == DIV_LAST) begin
						total_q <= {dvd_q[14:0], ge};
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!q_full) begin
						cur_len_q <= cur_len;
						left_q    <= left_n;
						if (frag_end) begin
							pos_q <= '0;
							idx_q <= frame_end ? 16'd0 : idx_q + 16'd1;
						end else begin
							pos_q <= pos_n;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pixel_value;
			rem_q <= '0;
			dvd_q <= dvd_init;
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[15:0], ge};
		end
	end

endmodule
`default_nettype wire

// ===== sv/ffp_queue.sv =====
`default_nettype none
module ffp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  ffp_pkg::desc_t      din,
	output logic                q_full,
	input  wire logic           rd,
	output ffp_pkg::desc_t      dout,
	output logic                q_empty
);

	ffp_pkg::desc_t mem_q [ffp_pkg::QUEUE_DEPTH];
	logic [ffp_pkg::QUEUE_PTR_W-1:0] wptr_q, rptr_q;
	logic [ffp_pkg::QUEUE_PTR_W:0]   count_q;
	logic do_wr, do_rd;

	assign q_full  = (count_q == (ffp_pkg::QUEUE_PTR_W+1)'(ffp_pkg::QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign dout    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + (ffp_pkg::QUEUE_PTR_W)'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + (ffp_pkg::QUEUE_PTR_W)'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + (ffp_pkg::QUEUE_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (ffp_pkg::QUEUE_PTR_W+1)'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/ffp_back.sv =====
`default_nettype none
module ffp_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      q_empty,
	input  ffp_pkg::desc_t q_desc,
	output logic           q_pop,
	output logic           empty,
	input  wire logic      pop,
	output logic [7:0]     out_byte,
	output logic           run_last,
	output logic           frame_last,
	output logic [31:0]    frames_sent
);

	localparam logic [3:0] PH_START = 4'd0;
	localparam logic [3:0] PH_IDX_H = 4'd1;
	localparam logic [3:0] PH_IDX_L = 4'd2;
	localparam logic [3:0] PH_TOT_H = 4'd3;
	localparam logic [3:0] PH_TOT_L = 4'd4;
	localparam logic [3:0] PH_LEN_H = 4'd5;
	localparam logic [3:0] PH_LEN_L = 4'd6;
	localparam logic [3:0] PH_PIXEL = 4'd7;
	localparam logic [3:0] PH_END   = 4'd8;

	ffp_pkg::desc_t d_q;
	logic        busy_q;
	logic [3:0]  ph_q;
	logic [31:0] done_q;
	logic        out_vld_q;

	logic        advance, last_byte, final_end;
	logic [7:0]  byte_sel;

	assign empty     = !out_vld_q;
	assign advance   = busy_q && (!out_vld_q || pop);
	assign last_byte = (ph_q == PH_END) || (ph_q == PH_PIXEL && !d_q.frag_end);
	assign final_end = (ph_q == PH_END) && d_q.frame_end;
	assign q_pop     = !q_empty && (!busy_q || (advance && last_byte));

	always_comb begin
		case (ph_q)
			PH_START: byte_sel = ffp_pkg::START_BYTE;
			PH_IDX_H: byte_sel = d_q.frag_index[15:8];
			PH_IDX_L: byte_sel = d_q.frag_index[7:0];
			PH_TOT_H: byte_sel = d_q.frag_total[15:8];
			PH_TOT_L: byte_sel = d_q.frag_total[7:0];
			PH_LEN_H: byte_sel = d_q.pay_len[15:8];
			PH_LEN_L: byte_sel = d_q.pay_len[7:0];
			PH_PIXEL: byte_sel = d_q.pixel;
			PH_END:   byte_sel = ffp_pkg::END_BYTE;
			default:  byte_sel = ffp_pkg::END_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			ph_q      <= PH_START;
			done_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (advance) begin
				out_vld_q <= 1'b1;
				if (final_end) begin
					done_q <= done_q + 32'd1;
				end
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end

			if (q_pop) begin
				busy_q <= 1'b1;
				ph_q   <= q_desc.hdr ? PH_START : PH_PIXEL;
			end else if (advance) begin
				if (last_byte) begin
					busy_q <= 1'b0;
				end else begin
					ph_q <= ph_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			d_q <= q_desc;
		end
		if (advance) begin
			out_byte    <= byte_sel;
			run_last    <= last_byte;
			frame_last  <= final_end;
			// final end byte already carries the new frame count
			frames_sent <= final_end ? done_q + 32'd1 : done_q;
		end
	end

endmodule
`default_nettype wire

// ===== sv/frame_fragment_packetizer.sv =====
// Fragment packetizer with start and end byte framing.
// Input channel: pixel_value is taken at a clock edge with push high and full low,
// one frame byte per item. Results: out_byte with run_last, frame_last and
// frames_sent is offered while empty is low and taken with pop.
// Each fragment goes out as 0xFF, sequence number, fragment count, payload length
// (16 bit each, high byte first), the payload bytes and a closing 0xFE.
// Registers frame_length (index 0) and payload_limit (index 1) are written through
// cfg_we/cfg_index/cfg_data; the user writes them only while the block is idle,
// which the block itself does not enforce; other indexes are ignored.
// An item passes the front end in a capture and a classify step; the item that
// opens a frame first runs a 17-step bit-serial divider for the fragment count.
// The back end sends one byte a cycle while it has items and the receiver pops;
// each item gives 1 to 9 output bytes.
// A 4-entry queue sits between the two, so input keeps flowing while the receiver
// stalls until that queue fills; a stalled result holds on the ports unchanged.
// Reset clears the frame state, the frame counter and the queue and loads the
// register defaults (frame length 12288, payload limit 256).
`default_nettype none
module frame_fragment_packetizer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [7:0]                    pixel_value,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [7:0]                         out_byte,
	output logic                               run_last,
	output logic                               frame_last,
	output logic [31:0]                        frames_sent,
	input  wire logic                          cfg_we,
	input  wire logic [ffp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data
);

	ffp_pkg::desc_t fq_din, fq_dout;
	logic fq_push, fq_full, fq_pop, fq_empty;

	ffp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.pixel_value (pixel_value),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (fq_full),
		.q_push      (fq_push),
		.q_desc      (fq_din)
	);

	ffp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fq_push),
		.din     (fq_din),
		.q_full  (fq_full),
		.rd      (fq_pop),
		.dout    (fq_dout),
		.q_empty (fq_empty)
	);

	ffp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (fq_empty),
		.q_desc      (fq_dout),
		.q_pop       (fq_pop),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.frame_last  (frame_last),
		.frames_sent (frames_sent)
	);

endmodule
`default_nettype wire

// ===== tb/sv/packetizer_checker.sv =====
module packetizer_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic                          full,
	input  wire logic [7:0]                    pixel_value,
	input  wire logic                          empty,
	input  wire logic                          pop,
	input  wire logic [7:0]                    out_byte,
	input  wire logic                          run_last,
	input  wire logic                          frame_last,
	input  wire logic [31:0]                   frames_sent,
	input  wire logic                          cfg_we,
	input  wire logic [ffp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data,
	output int                                 pending,
	output int                                 mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  data;
		logic        run_last;
		logic        frame_last;
		logic [31:0] frames_sent;
	} stream_byte_t;

	stream_byte_t bytes_due[$];

	logic [15:0] frame_len_reg;
	logic [15:0] limit_reg;
	logic [15:0] frag_seq;
	logic [15:0] frag_pos;
	logic [15:0] seg_len;
	logic [15:0] frame_left;
	logic [15:0] frag_count;
	logic [31:0] frames_done;

	function automatic void queue_byte(input logic [7:0] data, input logic flast);
		bytes_due.push_back(stream_byte_t'{data: data, run_last: 1'b0, frame_last: flast,
			frames_sent: frames_done});
	endfunction

	// header (at a fragment start), payload byte and closing byte (at a fragment end) caused by one frame byte
	task automatic packetize(input logic [7:0] pixel);
		logic [16:0] lim;
		logic [16:0] len;
		logic        flast;
		lim = (limit_reg == 16'd0) ? 17'd1 : {1'b0, limit_reg};
		if (frame_left == 16'd0) begin
			len = (frame_len_reg == 16'd0) ? 17'd1 : {1'b0, frame_len_reg};
			frame_left = len[15:0];
			frag_count = 16'((len + lim - 17'd1) / lim);
			frag_seq = 16'd0;
			frag_pos = 16'd0;
		end
		if (frag_pos == 16'd0) begin
			seg_len = ({1'b0, frame_left} < lim) ? frame_left : lim[15:0];
			queue_byte(ffp_pkg::START_BYTE, 1'b0);
			queue_byte(frag_seq[15:8], 1'b0);
			queue_byte(frag_seq[7:0], 1'b0);
			queue_byte(frag_count[15:8], 1'b0);
			queue_byte(frag_count[7:0], 1'b0);
			queue_byte(seg_len[15:8], 1'b0);
			queue_byte(seg_len[7:0], 1'b0);
		end
		queue_byte(pixel, 1'b0);
		frag_pos = frag_pos + 16'd1;
		frame_left = frame_left - 16'd1;
		if (frag_pos >= seg_len || frame_left == 16'd0) begin
			flast = 1'b0;
			frag_pos = 16'd0;
			frag_seq = frag_seq + 16'd1;
			if (frame_left == 16'd0) begin
				flast = 1'b1;
				frames_done = frames_done + 32'd1;
				frag_seq = 16'd0;
			end
			queue_byte(ffp_pkg::END_BYTE, flast);
		end
		bytes_due[bytes_due.size() - 1].run_last = 1'b1;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] wanted);
		$display("%0t mismatch %s: got 'h%0h, expected 'h%0h", $time, what, seen, wanted);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		stream_byte_t want;
		if (!arst_n) begin
			frame_len_reg = 16'(ffp_pkg::RESET_FRAME_LENGTH);
			limit_reg = 16'(ffp_pkg::RESET_PAYLOAD_LIMIT);
			frag_seq = 16'd0;
			frag_pos = 16'd0;
			seg_len = 16'd0;
			frame_left = 16'd0;
			frag_count = 16'd0;
			frames_done = 32'd0;
			bytes_due.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ffp_pkg::REG_FRAME_LENGTH)
					frame_len_reg = cfg_data;
				else if (cfg_index == ffp_pkg::REG_PAYLOAD_LIMIT)
					limit_reg = cfg_data;
			end
			if (push && !full)
				packetize(pixel_value);
			if (pop && !empty) begin
				if (bytes_due.size() == 0) begin
					report_mismatch("out_byte with no item expected", 32'(out_byte), 32'd0);
				end else begin
					want = bytes_due.pop_front();
					if (out_byte !== want.data)
						report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
					if (run_last !== want.run_last)
						report_mismatch("run_last", 32'(run_last), 32'(want.run_last));
					if (frame_last !== want.frame_last)
						report_mismatch("frame_last", 32'(frame_last), 32'(want.frame_last));
					if (frames_sent !== want.frames_sent)
						report_mismatch("frames_sent", frames_sent, want.frames_sent);
				end
			end
			pending <= bytes_due.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 16;
	localparam int ITEM_TARGET   = 285;
	localparam logic [ffp_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [ffp_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          push = 1'b0;
	logic [7:0]                    pixel_value = 8'd0;
	logic                          pop = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [ffp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]                   cfg_data = 16'd0;
	logic                          full;
	logic                          empty;
	logic [7:0]                    out_byte;
	logic                          run_last;
	logic                          frame_last;
	logic [31:0]                   frames_sent;
	int                            pending;
	int                            mismatches;

	int gap_pct = 15;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int sent = 0;
	int idle_cycles = 0;

	frame_fragment_packetizer u_top (.*);

	packetizer_checker u_checker (.*);

	always #2 clk = ~clk;

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= gap_pct);
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	task automatic write_reg(input logic [ffp_pkg::CFG_IDX_W-1:0] index,
			input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [7:0] value);
		if ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		push <= 1'b1;
		pixel_value <= value;
		do @(posedge clk); while (full);
		sent++;
	endtask

	task automatic send_random(input int count);
		repeat (count) send_pixel(8'($urandom_range(255)));
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [15:0] flen;
		logic [15:0] plim;
		int          nframes;
		int          cur_len;
		int          take;
		int          cut;
		int          pick;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// remainder fragment at the end of the frame
		write_reg(ffp_pkg::REG_FRAME_LENGTH, 16'd5);
		write_reg(ffp_pkg::REG_PAYLOAD_LIMIT, 16'd2);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'hFE);
		send_pixel(8'h80);
		send_pixel(8'h7F);
		wait_drained();

		// zero length and zero limit both act as one
		write_reg(ffp_pkg::REG_FRAME_LENGTH, 16'd0);
		write_reg(ffp_pkg::REG_PAYLOAD_LIMIT, 16'd0);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		wait_drained();

		write_reg(REG_SPARE_2, 16'hFFFF);
		write_reg(REG_SPARE_3, 16'hFFFF);
		send_pixel(8'h01);
		wait_drained();

		// limit larger than the frame
		write_reg(ffp_pkg::REG_FRAME_LENGTH, 16'd3);
		write_reg(ffp_pkg::REG_PAYLOAD_LIMIT, 16'hFFFF);
		send_random(3);
		wait_drained();

		// limit and length rewritten inside an open frame
		write_reg(ffp_pkg::REG_FRAME_LENGTH, 16'd6);
		write_reg(ffp_pkg::REG_PAYLOAD_LIMIT, 16'd4);
		send_random(2);
		wait_drained();
		write_reg(ffp_pkg::REG_PAYLOAD_LIMIT, 16'd1);
		write_reg(ffp_pkg::REG_FRAME_LENGTH, 16'd3);
		send_random(4);
		wait_drained();
		send_random(3);
		wait_drained();

		// long stretch without idling on either side
		gap_pct <= 0;
		write_reg(ffp_pkg::REG_FRAME_LENGTH, 16'd40);
		write_reg(ffp_pkg::REG_PAYLOAD_LIMIT, 16'd7);
		send_random(80);
		wait_drained();

		// receiver holds off while items keep coming, so the input stalls
		gap_pct <= 15;
		write_reg(ffp_pkg::REG_FRAME_LENGTH, 16'd12);
		write_reg(ffp_pkg::REG_PAYLOAD_LIMIT, 16'd5);
		hold_asks <= hold_asks + 1;
		send_random(36);
		wait_drained();

		while (sent < ITEM_TARGET) begin
			flen = ($urandom_range(9) == 0) ? 16'($urandom_range(64, 25))
				: 16'($urandom_range(24, 0));
			pick = $urandom_range(19);
			if (pick == 0)
				plim = 16'd0;
			else if (pick == 1)
				plim = 16'hFFFF;
			else
				plim = 16'($urandom_range(int'(flen) + 2, 1));
			write_reg(ffp_pkg::REG_FRAME_LENGTH, flen);
			write_reg(ffp_pkg::REG_PAYLOAD_LIMIT, plim);
			gap_pct <= ($urandom_range(3) == 0) ? 0 : 15;
			nframes = $urandom_range(3, 1);
			cur_len = (flen == 16'd0) ? 1 : int'(flen);
			repeat (nframes) begin
				take = cur_len;
				if ($urandom_range(3) == 0 && take > 1) begin
					cut = $urandom_range(take - 1, 1);
					send_random(cut);
					wait_drained();
					if ($urandom_range(1) == 0) begin
						write_reg(ffp_pkg::REG_PAYLOAD_LIMIT,
							16'($urandom_range(int'(flen) + 2, 0)));
					end else begin
						// new length only applies from the next frame
						flen = 16'($urandom_range(24, 0));
						write_reg(ffp_pkg::REG_FRAME_LENGTH, flen);
					end
					take = take - cut;
				end
				send_random(take);
				cur_len = (flen == 16'd0) ? 1 : int'(flen);
			end
			wait_drained();
		end

		// largest registers: frame stays open, fragment count all ones
		gap_pct <= 15;
		write_reg(ffp_pkg::REG_FRAME_LENGTH, 16'hFFFF);
		write_reg(ffp_pkg::REG_PAYLOAD_LIMIT, 16'd1);
		send_random(6);
		wait_drained();
		write_reg(ffp_pkg::REG_PAYLOAD_LIMIT, 16'hFFFF);
		send_random(4);
		wait_drained();

		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
sv/ffp_pkg.sv
sv/ffp_front.sv
sv/ffp_queue.sv
sv/ffp_back.sv
sv/frame_fragment_packetizer.sv
tb/sv/packetizer_checker.sv
tb/sv/testbench.sv
